// File: hw/rtl/osl_pkg.sv
// ---------------------------------------------------------------------------
// Ordered set package
// Operation and status codes, and the command and status records that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package osl_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned OP_W = 2;
	localparam int unsigned ST_W = 3;
	localparam int unsigned ACT_W = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOWER  = 2'd2;

	localparam logic [ST_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [ST_W-1:0] ST_DUPE    = 3'd1;
	localparam logic [ST_W-1:0] ST_REMOVED = 3'd2;
	localparam logic [ST_W-1:0] ST_MISS    = 3'd3;
	localparam logic [ST_W-1:0] ST_FOUND   = 3'd4;
	localparam logic [ST_W-1:0] ST_NONE    = 3'd5;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd6;

	// What the store must do once the item has been looked up
	localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	typedef struct packed {
		logic load;     // capture item, open search window
		logic rd_mid;   // read the middle of the window
		logic step;     // narrow the window
		logic rd_pos;   // read the entry at the found position
		logic check;    // decide the result and the store action
		logic rd_shift; // read the neighbour of the moving slot
		logic wr_shift; // write it into the slot and move on
		logic finish;   // place the new key on insert, adjust the count
		logic emit;     // load the result register
	} osl_cmd_t;

	typedef struct packed {
		logic             lo_lt_hi;
		logic             pos_lt_cnt;
		logic [ACT_W-1:0] act;
		logic             shift_more;
		logic             out_busy;
	} osl_stat_t;

endpackage

// File: hw/rtl/osl_cmd_if.sv
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one operation and key per item.
// ---------------------------------------------------------------------------
interface osl_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [osl_pkg::OP_W-1:0]         operation;
	logic signed [osl_pkg::KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);
endinterface

// File: hw/rtl/osl_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status and key per item.
// ---------------------------------------------------------------------------
interface osl_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [osl_pkg::ST_W-1:0]         status;
	logic signed [osl_pkg::KEY_W-1:0] found_key;

	modport source (output valid, output status, output found_key, input ready);
	modport sink (input valid, input status, input found_key, output ready);
endinterface

// File: hw/rtl/osl_ctrl.sv
// ---------------------------------------------------------------------------
// Ordered set controller
// Sequences search, lookup, shifting and the response for one item.
// ---------------------------------------------------------------------------
module osl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  osl_pkg::osl_stat_t stat,
	output osl_pkg::osl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SRCH_RD  = 3'd1;
	localparam logic [2:0] S_SRCH_CMP = 3'd2;
	localparam logic [2:0] S_POS_CHK  = 3'd3;
	localparam logic [2:0] S_SHF_RD   = 3'd4;
	localparam logic [2:0] S_SHF_WR   = 3'd5;
	localparam logic [2:0] S_FIN      = 3'd6;
	localparam logic [2:0] S_RESP     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (stat.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_d = S_SRCH_CMP;
				end else begin
					cmd.rd_pos = stat.pos_lt_cnt;
					state_d = S_POS_CHK;
				end
			end
			S_SRCH_CMP: begin
				cmd.step = 1'b1;
				state_d = S_SRCH_RD;
			end
			S_POS_CHK: begin
				cmd.check = 1'b1;
				if (stat.act == osl_pkg::ACT_NONE) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SHF_RD;
				end
			end
			S_SHF_RD: begin
				if (stat.shift_more) begin
					cmd.rd_shift = 1'b1;
					state_d = S_SHF_WR;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SHF_WR: begin
				cmd.wr_shift = 1'b1;
				state_d = S_SHF_RD;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/osl_dp.sv
// ---------------------------------------------------------------------------
// Ordered set datapath
// Sorted key store, binary search window, shift pointer and result register.
// ---------------------------------------------------------------------------
module osl_dp #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  osl_pkg::osl_cmd_t                cmd,
	output osl_pkg::osl_stat_t               stat,
	input  logic [osl_pkg::OP_W-1:0]         in_operation,
	input  logic signed [osl_pkg::KEY_W-1:0] in_key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [osl_pkg::ST_W-1:0]         out_status,
	output logic signed [osl_pkg::KEY_W-1:0] out_found_key
);

	localparam int unsigned CW = (CAPACITY > 1) ? $clog2(CAPACITY + 1) : 1;
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [osl_pkg::KEY_W-1:0] sorted_keys_q [CAPACITY];
	logic [osl_pkg::KEY_W-1:0] rd_data_q;

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    lo_q;
	logic [CW-1:0]                    hi_q;
	logic [CW-1:0]                    idx_q;
	logic [osl_pkg::OP_W-1:0]         op_q;
	logic signed [osl_pkg::KEY_W-1:0] key_q;
	logic [osl_pkg::ACT_W-1:0]        act_q;
	logic [osl_pkg::ST_W-1:0]         res_status_q;
	logic [osl_pkg::KEY_W-1:0]        res_key_q;
	logic                             out_valid_q;
	logic [osl_pkg::ST_W-1:0]         out_status_q;
	logic [osl_pkg::KEY_W-1:0]        out_key_q;

	logic [CW-1:0]             mid;
	logic                      pos_lt_cnt;
	logic                      hit;
	logic                      full;
	logic [osl_pkg::ST_W-1:0]  chk_status;
	logic [osl_pkg::KEY_W-1:0] chk_key;
	logic [osl_pkg::ACT_W-1:0] chk_act;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [osl_pkg::KEY_W-1:0] wr_data;
	logic [CW-1:0]             shift_src;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	// lo_q holds the lower-bound position once the window has closed
	assign pos_lt_cnt = (lo_q < count_q);
	assign hit = pos_lt_cnt && ($signed(rd_data_q) == key_q);
	assign full = (count_q == CAP_C);

	always_comb begin
		chk_status = osl_pkg::ST_MISS;
		chk_key = '0;
		chk_act = osl_pkg::ACT_NONE;
		unique case (op_q)
			osl_pkg::OP_ADD: begin
				if (hit) begin
					chk_status = osl_pkg::ST_DUPE;
				end else if (full) begin
					chk_status = osl_pkg::ST_FULL;
				end else begin
					chk_status = osl_pkg::ST_ADDED;
					chk_act = osl_pkg::ACT_INSERT;
				end
			end
			osl_pkg::OP_REMOVE: begin
				if (hit) begin
					chk_status = osl_pkg::ST_REMOVED;
					chk_act = osl_pkg::ACT_DELETE;
				end
			end
			osl_pkg::OP_LOWER: begin
				if (pos_lt_cnt) begin
					chk_status = osl_pkg::ST_FOUND;
					chk_key = rd_data_q;
				end else begin
					chk_status = osl_pkg::ST_NONE;
				end
			end
			default: begin
				chk_status = osl_pkg::ST_MISS;
			end
		endcase
	end

	// Insert walks down from the count, delete walks up from the hole
	assign shift_src = (act_q == osl_pkg::ACT_INSERT) ? (idx_q - ONE_C) : (idx_q + ONE_C);

	always_comb begin
		stat.lo_lt_hi = (lo_q < hi_q);
		stat.pos_lt_cnt = pos_lt_cnt;
		stat.act = chk_act;
		stat.out_busy = out_valid_q && !out_ready;
		if (act_q == osl_pkg::ACT_INSERT) begin
			stat.shift_more = (idx_q > lo_q);
		end else begin
			stat.shift_more = ((idx_q + ONE_C) < count_q);
		end
	end

	always_comb begin
		rd_en = cmd.rd_mid || cmd.rd_pos || cmd.rd_shift;
		priority if (cmd.rd_mid) begin
			rd_addr = mid[AW-1:0];
		end else if (cmd.rd_shift) begin
			rd_addr = shift_src[AW-1:0];
		end else begin
			rd_addr = lo_q[AW-1:0];
		end
		wr_en = cmd.wr_shift || (cmd.finish && (act_q == osl_pkg::ACT_INSERT));
		if (cmd.wr_shift) begin
			wr_addr = idx_q[AW-1:0];
			wr_data = rd_data_q;
		end else begin
			wr_addr = lo_q[AW-1:0];
			wr_data = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sorted_keys_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= sorted_keys_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_operation;
			key_q <= in_key;
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.step) begin
			if ($signed(rd_data_q) < key_q) begin
				lo_q <= mid + ONE_C;
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.check) begin
			act_q <= chk_act;
			res_status_q <= chk_status;
			res_key_q <= chk_key;
			idx_q <= (chk_act == osl_pkg::ACT_INSERT) ? count_q : lo_q;
		end else if (cmd.wr_shift) begin
			idx_q <= shift_src;
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_key_q <= res_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				if (act_q == osl_pkg::ACT_INSERT) begin
					count_q <= count_q + ONE_C;
				end else begin
					count_q <= count_q - ONE_C;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_found_key = $signed(out_key_q);

endmodule

// File: hw/rtl/ordered_set_lower_bound.sv
// ---------------------------------------------------------------------------
// Ordered set with lower-bound search
// Bounded set of distinct signed keys: add, remove and lower-bound query.
// ---------------------------------------------------------------------------
// Usage:
//  cmd carries one item (operation, key); rsp returns one item (status,
//  found_key) per command, in order. found_key is zero unless status is found.
//  Keys sit ascending in a single-port-read, single-port-write memory of
//  CAPACITY entries. An item is taken only while the controller is idle.
//  Steps per item, with n keys stored, from the accept to the emit: accept,
//    a read and a compare per binary search step (at most ceil(log2(n+1))
//    steps), then the window-closed read, the check and the response.
//    Insert or remove adds a read and a write per entry shifted, then the
//    loop exit and the finish.
//  The search loop and the shift loop both go through the one memory read
//  port, whose data is registered, so each step has a read state first.
//  The response sits in an output register; a new command is accepted while
//  it waits. When rsp stalls, a finished item holds in the controller until
//  the output register frees. Reset empties the set at once; the memory
//  itself is not cleared, as entries above the count are never read.
// ---------------------------------------------------------------------------
module ordered_set_lower_bound #(
	parameter int unsigned CAPACITY = 256
) (
	input logic      clk,
	input logic      arst_n,
	osl_cmd_if.sink  cmd,
	osl_rsp_if.source rsp
);

	osl_pkg::osl_cmd_t  ctl_cmd;
	osl_pkg::osl_stat_t ctl_stat;

	osl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (ctl_stat),
		.cmd      (ctl_cmd)
	);

	osl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.stat          (ctl_stat),
		.in_operation  (cmd.operation),
		.in_key        (cmd.key),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_found_key (rsp.found_key)
	);

endmodule

// File: verif/ordered_set_lower_bound_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Ordered set with lower-bound search: testbench
// Drives add, remove and lower-bound items into the set and keeps a sorted
// queue of its own as the expected contents. Each response item is compared
// with the oldest predicted status and key. Both channels idle at random in throttled tests.
// The set is taken through empty, mixed use, full and back to empty.
// ---------------------------------------------------------------------------
module ordered_set_lower_bound_tb;

	localparam int unsigned CAPACITY = 256;
	localparam logic [osl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [osl_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [osl_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
	// longest search plus a full shift, taken several times over
	localparam int STALL_LIMIT = 4000;
	localparam int END_CYCLES = 2 * CAPACITY + 64;

	typedef struct {
		logic [osl_pkg::ST_W-1:0]         status;
		logic signed [osl_pkg::KEY_W-1:0] found_key;
	} set_rsp_t;

	logic clk;
	logic arst_n;

	osl_cmd_if cmd_ch();
	osl_rsp_if rsp_ch();

	ordered_set_lower_bound #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	logic signed [osl_pkg::KEY_W-1:0] set_keys[$];   // expected contents, ascending
	set_rsp_t                         expected_rsp[$];
	int                               mismatches = 0;
	int                               quiet_cycles = 0;
	int                               rsp_hold = 0;
	bit                               throttle = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = osl_pkg::OP_ADD;
		cmd_ch.key = '0;
		rsp_ch.ready = 1'b0;
	end

	always #5 clk = ~clk;

	// Expected effect of one accepted item on the set, and its response
	function automatic void apply_set_command(input logic [osl_pkg::OP_W-1:0] op,
			input logic signed [osl_pkg::KEY_W-1:0] item_key);
		int       pos;
		bit       hit;
		set_rsp_t r;
		pos = 0;
		while (pos < set_keys.size() && set_keys[pos] < item_key)
			pos++;
		hit = (pos < set_keys.size()) && (set_keys[pos] == item_key);
		r.status = osl_pkg::ST_MISS;
		r.found_key = '0;
		case (op)
			osl_pkg::OP_ADD: begin
				if (hit)
					r.status = osl_pkg::ST_DUPE;
				else if (set_keys.size() >= CAPACITY)
					r.status = osl_pkg::ST_FULL;
				else begin
					set_keys.insert(pos, item_key);
					r.status = osl_pkg::ST_ADDED;
				end
			end
			osl_pkg::OP_REMOVE: begin
				if (hit) begin
					set_keys.delete(pos);
					r.status = osl_pkg::ST_REMOVED;
				end
			end
			osl_pkg::OP_LOWER: begin
				if (pos < set_keys.size()) begin
					r.status = osl_pkg::ST_FOUND;
					r.found_key = set_keys[pos];
				end else
					r.status = osl_pkg::ST_NONE;
			end
			default: ;
		endcase
		expected_rsp.push_back(r);
	endfunction

	// A stored key with hit_pct percent chance, else a narrow or full-range key
	function automatic logic signed [osl_pkg::KEY_W-1:0] pick_key(input int hit_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (set_keys.size() > 0 && roll < hit_pct)
			return set_keys[$urandom_range(0, set_keys.size() - 1)];
		if (roll[0])
			return int'($urandom_range(0, 127)) - 64;
		return $urandom;
	endfunction

	task automatic send_command(input logic [osl_pkg::OP_W-1:0] op,
			input logic signed [osl_pkg::KEY_W-1:0] item_key);
		int gap;
		gap = throttle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.key <= item_key;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		apply_set_command(op, item_key);
	endtask

	// Response side: check each item, then hold ready low for a random while
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with nothing expected: status %0d key %0d",
						$time, rsp_ch.status, rsp_ch.found_key);
					mismatches++;
				end else begin
					if (rsp_ch.status !== expected_rsp[0].status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							expected_rsp[0].status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.found_key !== expected_rsp[0].found_key) begin
						$display("%0t: found_key expected %0d actual %0d", $time,
							expected_rsp[0].found_key, rsp_ch.found_key);
						mismatches++;
					end
					void'(expected_rsp.pop_front());
				end
				rsp_hold = throttle ? $urandom_range(0, 15) : 0;
			end
			if (rsp_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Empty set, field extremes, every operation and the unused code
	task automatic test_directed();
		throttle = 0;
		send_command(osl_pkg::OP_LOWER, 0);
		send_command(osl_pkg::OP_REMOVE, 5);
		send_command(OP_UNUSED, -1);
		send_command(osl_pkg::OP_ADD, KEY_MAX);
		send_command(osl_pkg::OP_ADD, KEY_MIN);
		send_command(osl_pkg::OP_ADD, 0);
		send_command(osl_pkg::OP_ADD, 0);
		send_command(osl_pkg::OP_LOWER, KEY_MIN);
		send_command(osl_pkg::OP_LOWER, KEY_MIN + 1);
		send_command(osl_pkg::OP_LOWER, 1);
		send_command(osl_pkg::OP_LOWER, KEY_MAX);
		send_command(osl_pkg::OP_ADD, -1);
		send_command(osl_pkg::OP_LOWER, -5);
		send_command(OP_UNUSED, 0);
		send_command(osl_pkg::OP_LOWER, 0);
		send_command(osl_pkg::OP_REMOVE, KEY_MIN);
		send_command(osl_pkg::OP_REMOVE, KEY_MIN);
		send_command(osl_pkg::OP_LOWER, KEY_MIN);
		send_command(osl_pkg::OP_REMOVE, KEY_MAX);
		send_command(osl_pkg::OP_LOWER, 1);
		send_command(osl_pkg::OP_ADD, 32'sh5555_AAAA);
		send_command(osl_pkg::OP_ADD, 32'shAAAA_5555);
		send_command(osl_pkg::OP_REMOVE, 0);
		send_command(osl_pkg::OP_REMOVE, -1);
	endtask

	task automatic test_random_mix(input int n_items);
		int roll;
		throttle = 1;
		for (int i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				send_command(osl_pkg::OP_ADD, pick_key(30));
			else if (roll < 65)
				send_command(osl_pkg::OP_REMOVE, pick_key(60));
			else if (roll < 95)
				send_command(osl_pkg::OP_LOWER, pick_key(40));
			else
				send_command(OP_UNUSED, pick_key(50));
		end
	endtask

	// Grow the set to capacity, then hit it with adds, duplicates, queries and unused codes
	task automatic test_fill_to_capacity();
		int roll;
		int n;
		throttle = 1;
		n = 0;
		while (set_keys.size() < CAPACITY && n < 400) begin
			roll = $urandom_range(0, 99);
			if (roll < 80)
				send_command(osl_pkg::OP_ADD, $urandom);
			else if (roll < 88)
				send_command(osl_pkg::OP_ADD, pick_key(100));
			else
				send_command(osl_pkg::OP_LOWER, pick_key(20));
			n++;
		end
		for (int i = 0; i < 30; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 30)
				send_command(osl_pkg::OP_ADD, pick_key(0));
			else if (roll < 55)
				send_command(osl_pkg::OP_ADD, pick_key(100));
			else if (roll < 85)
				send_command(osl_pkg::OP_LOWER, pick_key(50));
			else
				send_command(OP_UNUSED, pick_key(50));
		end
		// one slot freed: the first new key goes in, the next finds the set full
		send_command(osl_pkg::OP_REMOVE, pick_key(100));
		send_command(osl_pkg::OP_ADD, $urandom);
		send_command(osl_pkg::OP_ADD, $urandom);
		send_command(osl_pkg::OP_ADD, KEY_MIN);
		send_command(osl_pkg::OP_LOWER, KEY_MIN);
	endtask

	task automatic test_drain();
		int roll;
		int n;
		n = 0;
		while (set_keys.size() > 0 && n < 360) begin
			throttle = (n >= 40);
			roll = $urandom_range(0, 99);
			if (roll < 80)
				send_command(osl_pkg::OP_REMOVE, pick_key(100));
			else if (roll < 90)
				send_command(osl_pkg::OP_LOWER, pick_key(30));
			else
				send_command(osl_pkg::OP_REMOVE, pick_key(0));
			n++;
		end
		send_command(osl_pkg::OP_LOWER, KEY_MIN);
		send_command(osl_pkg::OP_REMOVE, KEY_MAX);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(150);
		test_fill_to_capacity();
		test_drain();
		cmd_ch.valid <= 1'b0;
		while (expected_rsp.size() > 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/osl_pkg.sv
hw/rtl/osl_cmd_if.sv
hw/rtl/osl_rsp_if.sv
hw/rtl/osl_ctrl.sv
hw/rtl/osl_dp.sv
hw/rtl/ordered_set_lower_bound.sv
verif/ordered_set_lower_bound_tb.sv
